@@ hdl/ray_box_slab_test_core_defines.svh @@
// Assertion macros used by the ray box slab test top level.
`ifndef RAY_BOX_SLAB_TEST_CORE_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_CORE_DEFINES_SVH

// Checks that the consequent holds in the cycle after the antecedent.
`define RBST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define RBST_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ hdl/rbst_pkg.sv @@
// Types, constants and helper functions of the ray box slab test.
`default_nettype none
package rbst_pkg;

	localparam int COORD_BITS  = 32;
	localparam int FRAC_BITS   = 16;
	localparam int NUM_AXES    = 3;

	localparam int CENTER_W    = 32;
	localparam int HALF_W      = 30;
	localparam int ORIGIN_W    = 31;
	localparam int INV_W       = 32;
	localparam int LIMIT_W     = 32;

	localparam int DIFF_W      = 34;
	localparam int MAG_W       = DIFF_W - 1;
	localparam int HI_W        = MAG_W - FRAC_BITS;
	localparam int PH_W        = HI_W + INV_W;
	localparam int PL_W        = FRAC_BITS + INV_W;
	localparam int M_W         = PH_W + 1;
	localparam int CMP_W       = (COORD_BITS > LIMIT_W) ? COORD_BITS : LIMIT_W;

	localparam int SLAB_STAGES  = 5;
	localparam int MERGE_STAGES = 3;
	localparam int NUM_STAGES   = SLAB_STAGES + MERGE_STAGES;

	localparam int S_TDATA_W    = 224;
	localparam int M_TDATA_W    = 8;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Z = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_X   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_Y   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_Z   = 3'd5;

	localparam logic [CENTER_W-1:0] CENTER_RESET = '0;
	localparam logic [HALF_W-1:0]   HALF_RESET   = HALF_W'(65536);

	localparam logic [M_W-1:0] SAT_NEG = M_W'(1) << (COORD_BITS - 1);
	localparam logic [M_W-1:0] SAT_POS = SAT_NEG - M_W'(1);

	// Input transfer layout, last declared field in the lowest bits.
	typedef struct packed {
		logic signed [LIMIT_W-1:0]  t_limit;
		logic                       dir_neg_z;
		logic                       dir_neg_y;
		logic                       dir_neg_x;
		logic signed [INV_W-1:0]    inv_dir_z;
		logic signed [INV_W-1:0]    inv_dir_y;
		logic signed [INV_W-1:0]    inv_dir_x;
		logic signed [ORIGIN_W-1:0] ray_origin_z;
		logic signed [ORIGIN_W-1:0] ray_origin_y;
		logic signed [ORIGIN_W-1:0] ray_origin_x;
	} ray_t;

	typedef struct packed {
		logic signed [CENTER_W-1:0] center;
		logic [HALF_W-1:0]          half;
		logic signed [ORIGIN_W-1:0] origin;
		logic signed [INV_W-1:0]    inv;
		logic                       neg;
	} axis_in_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] tmin;
		logic signed [COORD_BITS-1:0] tmax;
	} interval_t;

	function automatic logic [MAG_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
		logic signed [DIFF_W-1:0] nd;
		nd = -d;
		return d[DIFF_W-1] ? nd[MAG_W-1:0] : d[MAG_W-1:0];
	endfunction

	function automatic logic [COORD_BITS-1:0] sat_mag(input logic [M_W-1:0] m,
		input logic sgn);
		logic [M_W-1:0] lim;
		lim = sgn ? SAT_NEG : SAT_POS;
		return (m > lim) ? lim[COORD_BITS-1:0] : m[COORD_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

@@ hdl/ray_box_slab_test_core.sv @@
// Ray against axis-aligned box test, top level.
//
// One ray enters per transfer on the s_axis channel and yields exactly one
// transfer on the m_axis channel, whose bit 0 is the hit flag. Rays are
// independent and one may enter in every cycle unless the output stalls.
// The pipeline has five stages per axis (face distances, magnitudes, split
// 17x32 and 16x32 products, sum with saturation, sign and swap) and three
// for the interval intersection and the final compare. Throughput is one
// ray per cycle while the receiver accepts results.
// The box is set through the cfg port; writes take effect at once. Writes
// are to be made while no ray is in flight; the block does not enforce it.
// Reset clears all stage valid bits and loads a unit box at the origin.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready falls, so no ray is lost or repeated.
`default_nettype none
`include "ray_box_slab_test_core_defines.svh"
module ray_box_slab_test_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// ray_origin_x, ray_origin_y, ray_origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
	// dir_neg_x, dir_neg_y, dir_neg_z, t_limit
	input  logic [rbst_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// hit, then zero padding
	output logic [rbst_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	input  logic                               cfg_wen,
	input  logic [rbst_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rbst_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rbst_pkg::*;

	logic signed [CENTER_W-1:0] center_q [NUM_AXES];
	logic [HALF_W-1:0]          half_q   [NUM_AXES];

	ray_t                       ray;
	axis_in_t                   axis_in  [NUM_AXES];
	interval_t                  interval [NUM_AXES];
	logic signed [LIMIT_W-1:0]  tl_dly_s [SLAB_STAGES];
	logic [NUM_STAGES:1]        valid_pipe_q;
	logic                       en;
	logic                       hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				center_q[i] <= CENTER_RESET;
				half_q[i]   <= HALF_RESET;
			end
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_CENTER_X: center_q[0] <= cfg_data;
				REG_CENTER_Y: center_q[1] <= cfg_data;
				REG_CENTER_Z: center_q[2] <= cfg_data;
				REG_HALF_X:   half_q[0]   <= cfg_data[HALF_W-1:0];
				REG_HALF_Y:   half_q[1]   <= cfg_data[HALF_W-1:0];
				REG_HALF_Z:   half_q[2]   <= cfg_data[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	assign ray = s_axis_tdata;

	assign axis_in[0] = '{center: center_q[0], half: half_q[0], origin: ray.ray_origin_x,
		inv: ray.inv_dir_x, neg: ray.dir_neg_x};
	assign axis_in[1] = '{center: center_q[1], half: half_q[1], origin: ray.ray_origin_y,
		inv: ray.inv_dir_y, neg: ray.dir_neg_y};
	assign axis_in[2] = '{center: center_q[2], half: half_q[2], origin: ray.ray_origin_z,
		inv: ray.inv_dir_z, neg: ray.dir_neg_z};

	assign en            = !valid_pipe_q[NUM_STAGES] || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_pipe_q <= '0;
		end else if (en) begin
			valid_pipe_q <= {valid_pipe_q[NUM_STAGES-1:1], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tl_dly_s[0] <= ray.t_limit;
			for (int i = 1; i < SLAB_STAGES; i++) begin
				tl_dly_s[i] <= tl_dly_s[i-1];
			end
		end
	end

	rbst_slab u_slab_x (
		.clk      (clk),
		.en       (en),
		.axis_in  (axis_in[0]),
		.interval (interval[0])
	);

	rbst_slab u_slab_y (
		.clk      (clk),
		.en       (en),
		.axis_in  (axis_in[1]),
		.interval (interval[1])
	);

	rbst_slab u_slab_z (
		.clk      (clk),
		.en       (en),
		.axis_in  (axis_in[2]),
		.interval (interval[2])
	);

	rbst_merge u_merge (
		.clk     (clk),
		.en      (en),
		.ix      (interval[0]),
		.iy      (interval[1]),
		.iz      (interval[2]),
		.t_limit (tl_dly_s[SLAB_STAGES-1]),
		.hit     (hit)
	);

	assign m_axis_tvalid = valid_pipe_q[NUM_STAGES];
	assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, hit};

	`RBST_ASSERT_NEXT(a_entry_tracks_input, clk, arst_n, en, valid_pipe_q[1] == $past(s_axis_tvalid), "input valid not captured in first stage")
	`RBST_ASSERT_NEXT(a_stall_holds_pipe, clk, arst_n, !en, $stable(valid_pipe_q), "pipeline valid bits changed during a stall")
	`RBST_ASSERT_NEXT(a_last_stage_fills, clk, arst_n, en && valid_pipe_q[NUM_STAGES-1], m_axis_tvalid, "item lost before the output stage")
	`RBST_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input stalled while output stage is empty")

endmodule
`default_nettype wire

@@ hdl/rbst_slab.sv @@
// Per-axis slab: face distances, fixed-point products, saturation and swap.
`default_nettype none
module rbst_slab (
	input  logic                clk,
	input  logic                en,
	input  rbst_pkg::axis_in_t  axis_in,
	output rbst_pkg::interval_t interval
);
	import rbst_pkg::*;

	logic signed [DIFF_W-1:0] c_ext, h_ext, o_ext;
	logic signed [DIFF_W-1:0] d_lo_s1, d_hi_s1;
	logic signed [INV_W-1:0]  inv_s1;
	logic                     neg_s1;

	logic [INV_W-1:0]         inv_neg;
	logic [MAG_W-1:0]         ad_lo_s2, ad_hi_s2;
	logic [INV_W-1:0]         ai_s2;
	logic                     sgn_lo_s2, sgn_hi_s2, neg_s2;

	logic [PH_W-1:0]          ph_lo_s3, ph_hi_s3;
	logic [PL_W-1:0]          pl_lo_s3, pl_hi_s3;
	logic                     sgn_lo_s3, sgn_hi_s3, neg_s3;

	logic [M_W-1:0]           m_lo, m_hi;
	logic [COORD_BITS-1:0]    mag_lo_s4, mag_hi_s4;
	logic                     sgn_lo_s4, sgn_hi_s4, neg_s4;

	logic [COORD_BITS-1:0]    t_lo, t_hi;
	interval_t                interval_s5;

	assign c_ext = DIFF_W'(axis_in.center);
	assign h_ext = $signed(DIFF_W'(axis_in.half));
	assign o_ext = DIFF_W'(axis_in.origin);

	always_ff @(posedge clk) begin
		if (en) begin
			d_lo_s1 <= c_ext - h_ext - o_ext;
			d_hi_s1 <= c_ext + h_ext - o_ext;
			inv_s1  <= axis_in.inv;
			neg_s1  <= axis_in.neg;
		end
	end

	assign inv_neg = -inv_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ad_lo_s2  <= abs_diff(d_lo_s1);
			ad_hi_s2  <= abs_diff(d_hi_s1);
			ai_s2     <= inv_s1[INV_W-1] ? inv_neg : inv_s1;
			sgn_lo_s2 <= d_lo_s1[DIFF_W-1] ^ inv_s1[INV_W-1];
			sgn_hi_s2 <= d_hi_s1[DIFF_W-1] ^ inv_s1[INV_W-1];
			neg_s2    <= neg_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_lo_s3  <= PH_W'(ad_lo_s2[MAG_W-1:FRAC_BITS]) * PH_W'(ai_s2);
			ph_hi_s3  <= PH_W'(ad_hi_s2[MAG_W-1:FRAC_BITS]) * PH_W'(ai_s2);
			pl_lo_s3  <= PL_W'(ad_lo_s2[FRAC_BITS-1:0]) * PL_W'(ai_s2);
			pl_hi_s3  <= PL_W'(ad_hi_s2[FRAC_BITS-1:0]) * PL_W'(ai_s2);
			sgn_lo_s3 <= sgn_lo_s2;
			sgn_hi_s3 <= sgn_hi_s2;
			neg_s3    <= neg_s2;
		end
	end

	assign m_lo = M_W'(ph_lo_s3) + M_W'(pl_lo_s3 >> FRAC_BITS);
	assign m_hi = M_W'(ph_hi_s3) + M_W'(pl_hi_s3 >> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_lo_s4 <= sat_mag(m_lo, sgn_lo_s3);
			mag_hi_s4 <= sat_mag(m_hi, sgn_hi_s3);
			sgn_lo_s4 <= sgn_lo_s3;
			sgn_hi_s4 <= sgn_hi_s3;
			neg_s4    <= neg_s3;
		end
	end

	assign t_lo = sgn_lo_s4 ? -mag_lo_s4 : mag_lo_s4;
	assign t_hi = sgn_hi_s4 ? -mag_hi_s4 : mag_hi_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			interval_s5.tmin <= neg_s4 ? t_hi : t_lo;
			interval_s5.tmax <= neg_s4 ? t_lo : t_hi;
		end
	end

	assign interval = interval_s5;

endmodule
`default_nettype wire

@@ hdl/rbst_merge.sv @@
// Interval intersection of the three slabs and the final hit decision.
`default_nettype none
module rbst_merge (
	input  logic                          clk,
	input  logic                          en,
	input  rbst_pkg::interval_t           ix,
	input  rbst_pkg::interval_t           iy,
	input  rbst_pkg::interval_t           iz,
	input  logic signed [rbst_pkg::LIMIT_W-1:0] t_limit,
	output logic                          hit
);
	import rbst_pkg::*;

	logic                         pass_xy_s1;
	logic signed [COORD_BITS-1:0] tmin_xy_s1, tmax_xy_s1;
	interval_t                    iz_s1;
	logic signed [LIMIT_W-1:0]    tl_s1;

	logic                         pass_s2;
	logic signed [COORD_BITS-1:0] tmin_s2, tmax_s2;
	logic signed [LIMIT_W-1:0]    tl_s2;

	logic                         hit_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pass_xy_s1 <= !(ix.tmin > iy.tmax || iy.tmin > ix.tmax);
			tmin_xy_s1 <= (iy.tmin > ix.tmin) ? iy.tmin : ix.tmin;
			tmax_xy_s1 <= (iy.tmax < ix.tmax) ? iy.tmax : ix.tmax;
			iz_s1      <= iz;
			tl_s1      <= t_limit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pass_s2 <= pass_xy_s1 && !(tmin_xy_s1 > iz_s1.tmax || iz_s1.tmin > tmax_xy_s1);
			tmin_s2 <= (iz_s1.tmin > tmin_xy_s1) ? iz_s1.tmin : tmin_xy_s1;
			tmax_s2 <= (iz_s1.tmax < tmax_xy_s1) ? iz_s1.tmax : tmax_xy_s1;
			tl_s2   <= tl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s3 <= pass_s2 && !tmax_s2[COORD_BITS-1] && (|tmax_s2)
				&& (CMP_W'(tmin_s2) < CMP_W'(tl_s2));
		end
	end

	assign hit = hit_s3;

endmodule
`default_nettype wire

@@ test/ray_box_slab_test_core_tb.sv @@
// Self-checking testbench for the ray against axis-aligned box slab test core.
module ray_box_slab_test_core_tb;
	import rbst_pkg::*;

	localparam longint ONE       = 64'sd65536;
	localparam longint SAT_P     = 64'sh7FFF_FFFF;
	localparam longint SAT_N     = -64'sh8000_0000;
	localparam longint ORG_MAX   = 64'sh3FFF_FFFF;
	localparam longint ORG_MIN   = -64'sh4000_0000;
	localparam int     CYCLE_CAP = 400000;
	localparam int     PHASE_RAYS = 150;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	class hit_scoreboard;
		logic signed [CENTER_W-1:0] center [NUM_AXES];
		logic [HALF_W-1:0]          half [NUM_AXES];
		bit                         hit_queue [$];
		int                         failures;

		function new();
			for (int a = 0; a < NUM_AXES; a++) begin
				center[a] = CENTER_RESET;
				half[a]   = HALF_RESET;
			end
			failures = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z: begin
					center[2'(idx - REG_CENTER_X)] = data;
				end
				REG_HALF_X, REG_HALF_Y, REG_HALF_Z: begin
					half[2'(idx - REG_HALF_X)] = data[HALF_W-1:0];
				end
				default: ;
			endcase
		endfunction

		// Product truncated to Q16.16 and saturated to the coordinate width.
		function longint face_distance(longint d, longint inv);
			bit                neg;
			longint unsigned   ad;
			longint unsigned   ai;
			longint unsigned   m;
			longint unsigned   lim;
			neg = (d < 0) != (inv < 0);
			ad  = (d < 0) ? -d : d;
			ai  = (inv < 0) ? -inv : inv;
			m   = (ad >> 16) * ai + (((ad & 64'hFFFF) * ai) >> 16);
			lim = (64'd1 << (COORD_BITS - 1)) - 64'd1;
			if (neg) begin
				if (m > lim + 64'd1)
					m = lim + 64'd1;
				return -$signed(m);
			end
			if (m > lim)
				m = lim;
			return $signed(m);
		endfunction

		function bit predict_hit(ray_t r);
			longint org [NUM_AXES];
			longint inv [NUM_AXES];
			bit     ng [NUM_AXES];
			longint tmin [NUM_AXES];
			longint tmax [NUM_AXES];
			longint c, h, lo_f, hi_f, t_entry, t_exit, tl;
			org[0] = $signed(r.ray_origin_x);
			org[1] = $signed(r.ray_origin_y);
			org[2] = $signed(r.ray_origin_z);
			inv[0] = $signed(r.inv_dir_x);
			inv[1] = $signed(r.inv_dir_y);
			inv[2] = $signed(r.inv_dir_z);
			ng[0]  = r.dir_neg_x;
			ng[1]  = r.dir_neg_y;
			ng[2]  = r.dir_neg_z;
			tl     = $signed(r.t_limit);
			for (int a = 0; a < NUM_AXES; a++) begin
				c    = center[a];
				h    = longint'(half[a]);
				lo_f = face_distance(c - h - org[a], inv[a]);
				hi_f = face_distance(c + h - org[a], inv[a]);
				tmin[a] = ng[a] ? hi_f : lo_f;
				tmax[a] = ng[a] ? lo_f : hi_f;
			end
			if (tmin[0] > tmax[1] || tmin[1] > tmax[0])
				return 1'b0;
			t_entry = (tmin[1] > tmin[0]) ? tmin[1] : tmin[0];
			t_exit  = (tmax[1] < tmax[0]) ? tmax[1] : tmax[0];
			if (t_entry > tmax[2] || tmin[2] > t_exit)
				return 1'b0;
			if (tmin[2] > t_entry)
				t_entry = tmin[2];
			if (tmax[2] < t_exit)
				t_exit = tmax[2];
			return (t_exit > 0) && (t_entry < tl);
		endfunction

		function void report(string msg);
			failures++;
			if (failures <= 10)
				$display("%s", msg);
		endfunction

		function void note_ray(ray_t r);
			hit_queue = {hit_queue, predict_hit(r)};
		endfunction

		function void check_hit(logic [M_TDATA_W-1:0] data);
			bit want;
			if (hit_queue.size() == 0) begin
				report($sformatf("unexpected result transfer, hit=%0b", data[0]));
				return;
			end
			want = hit_queue.pop_front();
			if (data[0] !== want)
				report($sformatf("hit mismatch: expected %0b, got %0b", want, data[0]));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [S_TDATA_W-1:0]   s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [M_TDATA_W-1:0]   m_axis_tdata;
	logic                   cfg_wen;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	hit_scoreboard sb;
	bit            idling = 1'b1;
	int            cycles = 0;

	ray_box_slab_test_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$display("ray_box_slab_test_core_tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_ray(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_hit(m_axis_tdata);
		end
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (idling && $urandom_range(0, 9) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	function automatic ray_t make_ray(longint ox, oy, oz, ix, iy, iz,
		logic [2:0] ng, longint tl);
		ray_t r;
		r.ray_origin_x = ORIGIN_W'(ox);
		r.ray_origin_y = ORIGIN_W'(oy);
		r.ray_origin_z = ORIGIN_W'(oz);
		r.inv_dir_x    = INV_W'(ix);
		r.inv_dir_y    = INV_W'(iy);
		r.inv_dir_z    = INV_W'(iz);
		r.dir_neg_x    = ng[0];
		r.dir_neg_y    = ng[1];
		r.dir_neg_z    = ng[2];
		r.t_limit      = LIMIT_W'(tl);
		return r;
	endfunction

	// A ray placed near the current box and mostly pointed at it.
	function automatic ray_t aimed_ray();
		longint          org [NUM_AXES];
		longint          inv [NUM_AXES];
		logic [2:0]      ng;
		longint          c, mag, tl;
		longint unsigned reach;
		bit              toward_pos;
		for (int a = 0; a < NUM_AXES; a++) begin
			c     = sb.center[a];
			reach = 2 * longint'(sb.half[a]) + 4 * ONE;
			if (reach > 64'h3FFF_FFFF)
				reach = 64'h3FFF_FFFF;
			org[a] = c + longint'($urandom_range(0, 32'(2 * reach))) - longint'(reach);
			if (org[a] > ORG_MAX)
				org[a] = ORG_MAX;
			if (org[a] < ORG_MIN)
				org[a] = ORG_MIN;
			toward_pos = ($urandom_range(0, 4) < 3) ? (org[a] < c) : $urandom_range(0, 1);
			case ($urandom_range(0, 9))
				0: mag = -1;
				1: mag = 0;
				2: mag = $urandom_range(1, 32'h7FFF_FFFF);
				default: mag = $urandom_range(32'(ONE / 16), 32'(16 * ONE));
			endcase
			if (mag < 0)
				inv[a] = toward_pos ? SAT_P : SAT_N;
			else
				inv[a] = toward_pos ? mag : -mag;
			ng[a] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : !toward_pos;
		end
		case ($urandom_range(0, 5))
			0: tl = $signed($urandom);
			1: tl = SAT_P;
			2: tl = -longint'($urandom_range(0, 32'(4 * ONE)));
			default: tl = $urandom_range(0, 32'(32 * ONE));
		endcase
		return make_ray(org[0], org[1], org[2], inv[0], inv[1], inv[2], ng, tl);
	endfunction

	task automatic send_ray(input ray_t r);
		if (idling && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= r;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.hit_queue.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Half extents go out with random upper bits, which the block must drop.
	task automatic program_box(input longint cx, cy, cz, hx, hy, hz);
		write_reg(REG_CENTER_X, CFG_DATA_W'(cx));
		write_reg(REG_CENTER_Y, CFG_DATA_W'(cy));
		write_reg(REG_CENTER_Z, CFG_DATA_W'(cz));
		write_reg(REG_HALF_X, CFG_DATA_W'(hx) | ($urandom & 32'hC000_0000));
		write_reg(REG_HALF_Y, CFG_DATA_W'(hy) | ($urandom & 32'hC000_0000));
		write_reg(REG_HALF_Z, CFG_DATA_W'(hz) | ($urandom & 32'hC000_0000));
		write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
		cfg_wen <= 1'b0;
	endtask

	task automatic run_random(input int count);
		ray_t r;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 3) == 0)
				r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			else
				r = aimed_ray();
			send_ray(r);
		end
		drain();
	endtask

	function automatic longint small_coord(int units);
		return longint'($urandom_range(0, 32'(2 * units * ONE))) - units * ONE;
	endfunction

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_wen       = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Unit box at the origin for the directed rays.
		program_box(0, 0, 0, ONE, ONE, ONE);
		send_ray(make_ray(-5 * ONE, 0, 0, ONE, SAT_P, SAT_P, 3'b000, SAT_P));
		send_ray(make_ray(5 * ONE, 0, 0, -ONE, SAT_P, SAT_N, 3'b101, SAT_P));
		send_ray(make_ray(-5 * ONE, 5 * ONE, 0, ONE, SAT_P, SAT_P, 3'b000, SAT_P));
		// Faces passing exactly through the origin, with saturated inverses.
		send_ray(make_ray(-5 * ONE, ONE, 0, ONE, SAT_P, SAT_P, 3'b000, SAT_P));
		send_ray(make_ray(-5 * ONE, ONE, -ONE, ONE, SAT_N, SAT_N, 3'b110, SAT_P));
		// Entry equal to exit where the x and y slabs only touch.
		send_ray(make_ray(-2 * ONE, -4 * ONE, 0, ONE, ONE, SAT_P, 3'b000, SAT_P));
		// Exit exactly at zero.
		send_ray(make_ray(ONE, 0, 0, ONE, SAT_P, SAT_P, 3'b000, SAT_P));
		// Entry equal to the limit, then just below it.
		send_ray(make_ray(-2 * ONE, 0, 0, ONE, SAT_P, SAT_P, 3'b000, ONE));
		send_ray(make_ray(-2 * ONE, 0, 0, ONE, SAT_P, SAT_P, 3'b000, ONE + 1));
		send_ray(make_ray(0, 0, 0, ONE, SAT_P, SAT_P, 3'b000, -ONE));
		send_ray(make_ray(0, 0, 0, ONE, SAT_P, SAT_P, 3'b000, SAT_N));
		// Direction flags that disagree with the sign of the inverse.
		send_ray(make_ray(-5 * ONE, 0, 0, ONE, SAT_P, SAT_P, 3'b001, SAT_P));
		send_ray(make_ray(5 * ONE, 0, 0, -ONE, SAT_N, SAT_P, 3'b010, SAT_P));
		send_ray(make_ray(ORG_MAX, ORG_MAX, ORG_MAX, SAT_P, SAT_P, SAT_P, 3'b000, SAT_P));
		send_ray(make_ray(ORG_MIN, ORG_MIN, ORG_MIN, SAT_N, SAT_N, SAT_N, 3'b111, SAT_N));
		send_ray(make_ray(ORG_MIN, ORG_MAX, 0, SAT_P, SAT_N, 0, 3'b010, SAT_P));
		send_ray(make_ray(0, 0, 0, 0, 0, 0, 3'b000, SAT_P));
		send_ray(make_ray(-ONE / 2, ONE / 2, 0, -1, 1, -1, 3'b101, SAT_P));
		send_ray(make_ray(-3 * ONE, -3 * ONE, -3 * ONE, ONE, ONE, ONE, 3'b000, 0));
		run_random(PHASE_RAYS);

		program_box(small_coord(16), small_coord(16), small_coord(16),
			$urandom_range(32'(ONE / 4), 32'(8 * ONE)),
			$urandom_range(32'(ONE / 4), 32'(8 * ONE)),
			$urandom_range(32'(ONE / 4), 32'(8 * ONE)));
		run_random(PHASE_RAYS);

		program_box(SAT_P, SAT_N, 0, 64'h3FFF_FFFF, 0, 64'h3FFF_FFFF);
		run_random(PHASE_RAYS);

		program_box(small_coord(4), small_coord(4), small_coord(4), 0, 1, 0);
		run_random(PHASE_RAYS);

		program_box($signed($urandom), $signed($urandom), $signed($urandom),
			$urandom & 32'h3FFF_FFFF, $urandom & 32'h3FFF_FFFF, $urandom & 32'h3FFF_FFFF);
		run_random(PHASE_RAYS);

		idling = 1'b0;
		program_box(small_coord(8), small_coord(8), small_coord(8),
			$urandom_range(32'(ONE / 2), 32'(4 * ONE)),
			$urandom_range(32'(ONE / 2), 32'(4 * ONE)),
			$urandom_range(32'(ONE / 2), 32'(4 * ONE)));
		run_random(PHASE_RAYS);

		repeat (2 * NUM_STAGES) @(posedge clk);
		if (sb.hit_queue.size() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.hit_queue.size()));
		if (sb.failures == 0)
			$display("ray_box_slab_test_core_tb passed");
		else
			$display("ray_box_slab_test_core_tb failed");
		$finish;
	end
endmodule

@@ ray_box_slab_test_core.f @@
+incdir+hdl
hdl/rbst_pkg.sv
hdl/rbst_slab.sv
hdl/rbst_merge.sv
hdl/ray_box_slab_test_core.sv
test/ray_box_slab_test_core_tb.sv
